// File: rtl/bbd_pkg.sv
// Shared constants for the bounded byte deque: operation and status codes,
// register map and reset values. No dependencies.
package bbd_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_REAR    = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR     = 3'd3;
	localparam logic [OP_W-1:0] OP_REPLACE_REAR = 3'd4;
	localparam logic [OP_W-1:0] OP_SEARCH       = 3'd5;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam int          PADDR_W     = 3;
	localparam logic        REG_CAP_IDX = 1'b0;
	localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

endpackage

// File: rtl/bbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/bounded_byte_deque_unit.sv
// Bounded byte deque held as a circular buffer, with stream ports and an APB register port.
// Depends on bbd_pkg and bbd_ram.
//
// Each input word carries one operation (push or pop at either end, replace the rear byte,
// or search for a byte) and yields one result word with status, found flag, entry count and
// the front and rear bytes. All entries live in one RAM with a single registered read port,
// and a small sequencer drives that port. A push, pop or replace passes through EXEC, which
// updates the pointers and writes, then RDF, RDR and RDW, which read back the front and
// rear bytes into the result register; RDW holds while that register still holds a result
// not yet taken. A search on a non-empty deque first passes through SCAN, which compares
// the entries from the front in turn and stops at the first match. The next word is
// accepted as soon as the sequencer is idle, even while the previous result waits.
// Capacity register at address 0 (reset 16); the effective limit is min(capacity, DEPTH).
module bounded_byte_deque_unit #(
	parameter int DEPTH = bbd_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// tdata: op [2:0], value [10:3]
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,
	// tdata: status [1:0], found [2], entry_count [7:3], front_byte [15:8], rear_byte [23:16]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = bbd_pkg::COUNT_W;
	localparam int SW = ((IW > CW) ? IW : CW) + 1;
	localparam int BW = bbd_pkg::BYTE_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_RDF  = 6'b001000,
		ST_RDR  = 6'b010000,
		ST_RDW  = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [bbd_pkg::OP_W-1:0]    op_q;
	logic [BW-1:0]               value_q;
	logic [IW-1:0]               head_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               cap_q;
	logic [CW-1:0]               scan_q;
	logic                        cmp_vld_q;
	logic                        found_q;
	logic [bbd_pkg::STAT_W-1:0]  stat_q;
	logic [BW-1:0]               front_q;

	logic                        out_vld_q;
	logic [bbd_pkg::STAT_W-1:0]  out_stat_q;
	logic                        out_found_q;
	logic [CW-1:0]               out_count_q;
	logic [BW-1:0]               out_front_q;
	logic [BW-1:0]               out_rear_q;

	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;
	logic [IW-1:0]               ram_raddr;
	logic [BW-1:0]               ram_rdata;

	logic                        is_push;
	logic                        is_full;
	logic                        deque_empty;
	logic [IW-1:0]               head_dec;
	logic [IW-1:0]               rear_slot;
	logic                        hit_now;
	logic                        scan_issue;
	logic                        scan_done;
	logic                        out_free;
	logic                        cfg_wr;

	function automatic logic [IW-1:0] slot_of(logic [IW-1:0] base, logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (32'(s) >= DEPTH) begin
			s = s - SW'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == bbd_pkg::REG_CAP_IDX);
	assign prdata   = (paddr[2] == bbd_pkg::REG_CAP_IDX) ? {27'd0, cap_q} : 32'd0;

	assign is_push  = (op_q == bbd_pkg::OP_PUSH_FRONT) || (op_q == bbd_pkg::OP_PUSH_REAR);
	assign is_full  = (count_q >= cap_q) || (32'(count_q) >= DEPTH);
	assign deque_empty = (count_q == '0);
	assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign rear_slot = slot_of(head_q, count_q - CW'(1));

	assign hit_now    = cmp_vld_q && (ram_rdata == value_q);
	assign scan_issue = (scan_q < count_q) && !hit_now;
	assign scan_done  = hit_now || (!cmp_vld_q && !(scan_q < count_q));
	assign out_free   = !out_vld_q || m_tready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, count_q);
		if (state_q == ST_EXEC) begin
			if (is_push && !is_full) begin
				ram_we = 1'b1;
				if (op_q == bbd_pkg::OP_PUSH_FRONT) begin
					ram_waddr = head_dec;
				end
			end else if (op_q == bbd_pkg::OP_REPLACE_REAR && !deque_empty) begin
				ram_we    = 1'b1;
				ram_waddr = rear_slot;
			end
		end
	end

	always_comb begin
		unique case (state_q)
			ST_SCAN:        ram_raddr = slot_of(head_q, scan_q);
			ST_RDR, ST_RDW: ram_raddr = rear_slot;
			default:        ram_raddr = head_q;
		endcase
	end

	bbd_ram #(
		.WIDTH(BW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bbd_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			stat_q    <= bbd_pkg::STAT_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						found_q   <= 1'b0;
						scan_q    <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					stat_q  <= bbd_pkg::STAT_DONE;
					state_q <= ST_RDF;
					if (is_push) begin
						if (is_full) begin
							stat_q <= bbd_pkg::STAT_FULL;
						end else begin
							count_q <= count_q + CW'(1);
							if (op_q == bbd_pkg::OP_PUSH_FRONT) begin
								head_q <= head_dec;
							end
						end
					end else if (op_q <= bbd_pkg::OP_SEARCH) begin
						if (deque_empty) begin
							stat_q <= bbd_pkg::STAT_EMPTY;
						end else begin
							unique case (op_q)
								bbd_pkg::OP_POP_FRONT: begin
									head_q  <= slot_of(head_q, CW'(1));
									count_q <= count_q - CW'(1);
								end
								bbd_pkg::OP_POP_REAR: count_q <= count_q - CW'(1);
								bbd_pkg::OP_SEARCH:   state_q <= ST_SCAN;
								default: ;
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						cmp_vld_q <= 1'b0;
						state_q   <= ST_RDF;
					end else begin
						cmp_vld_q <= scan_issue;
						if (scan_issue) begin
							scan_q <= scan_q + CW'(1);
						end
					end
				end
				ST_RDF: state_q <= ST_RDR;
				ST_RDR: state_q <= ST_RDW;
				ST_RDW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tdata[2:0];
			value_q <= s_tdata[10:3];
		end
		if (state_q == ST_RDR) begin
			front_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RDW && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDW && out_free) begin
			out_stat_q  <= stat_q;
			out_found_q <= found_q;
			out_count_q <= count_q;
			out_front_q <= deque_empty ? '0 : front_q;
			out_rear_q  <= deque_empty ? '0 : ram_rdata;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_rear_q, out_front_q, out_count_q, out_found_q, out_stat_q};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count beyond depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_EXEC)
		else $error("accepted word not executed");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && is_push && !is_full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not advance count");

	a_found_search: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDF |-> !found_q || op_q == bbd_pkg::OP_SEARCH)
		else $error("found set outside search");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q <= count_q)
		else $error("scan index past count");
`endif

endmodule

// File: verif/tb_bounded_byte_deque_unit.sv
// Self-checking testbench for bounded_byte_deque_unit: directed and random deque operations
// over the stream ports, capacity writes over APB, results checked against a local shadow deque.
// Depends on bbd_pkg and the RTL of bounded_byte_deque_unit.
`timescale 1ns / 1ps

module tb_bounded_byte_deque_unit;
	import bbd_pkg::*;

	localparam int DEQUE_DEPTH = DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 24;
	localparam int REPORT_LIMIT = 20;
	localparam int SEGMENT_WORDS = 100;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam logic [PADDR_W-1:0] CAP_ADDR   = {REG_CAP_IDX, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0]  rear_byte;
		logic [BYTE_W-1:0]  front_byte;
		logic [COUNT_W-1:0] entry_count;
		logic               found;
		logic [STAT_W-1:0]  status;
	} deque_result_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// tdata: op [2:0], value [10:3]
	logic [15:0]        s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// tdata: status [1:0], found [2], entry_count [7:3], front_byte [15:8], rear_byte [23:16]
	logic [23:0]        m_tdata;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [31:0]        pwdata   = '0;
	logic [31:0]        prdata;
	logic               pready;

	logic [BYTE_W-1:0]  shadow_bytes [DEQUE_DEPTH];
	int                 shadow_head = 0;
	int                 shadow_count = 0;
	logic [COUNT_W-1:0] shadow_capacity = CAP_RESET;

	deque_result_t      expected_results [$];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 error_count = 0;
	int                 words_sent = 0;
	int                 applied_words = 0;
	int                 results_checked = 0;
	int                 capacity_writes = 0;
	int unsigned        cycle_count = 0;

	bounded_byte_deque_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
			CYCLE_LIMIT, expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic deque_result_t predict_deque_result(input logic [OP_W-1:0] op,
		input logic [BYTE_W-1:0] value);
		deque_result_t res;
		int lim;
		res = '0;
		res.status = STAT_DONE;
		lim = (shadow_capacity > DEQUE_DEPTH) ? DEQUE_DEPTH : int'(shadow_capacity);
		if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
			if (shadow_count >= lim) begin
				res.status = STAT_FULL;
			end else if (op == OP_PUSH_FRONT) begin
				shadow_head = (shadow_head + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
				shadow_bytes[shadow_head] = value;
				shadow_count++;
			end else begin
				shadow_bytes[(shadow_head + shadow_count) % DEQUE_DEPTH] = value;
				shadow_count++;
			end
		end else if (op <= OP_SEARCH) begin
			if (shadow_count == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				case (op)
					OP_POP_FRONT: begin
						shadow_head = (shadow_head + 1) % DEQUE_DEPTH;
						shadow_count--;
					end
					OP_POP_REAR: begin
						shadow_count--;
					end
					OP_REPLACE_REAR: begin
						shadow_bytes[(shadow_head + shadow_count - 1) % DEQUE_DEPTH] = value;
					end
					OP_SEARCH: begin
						for (int i = 0; i < shadow_count; i++)
							if (shadow_bytes[(shadow_head + i) % DEQUE_DEPTH] == value)
								res.found = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
		res.entry_count = COUNT_W'(shadow_count);
		if (shadow_count != 0) begin
			res.front_byte = shadow_bytes[shadow_head];
			res.rear_byte  = shadow_bytes[(shadow_head + shadow_count - 1) % DEQUE_DEPTH];
		end
		return res;
	endfunction

	function automatic void compare_field(input string field_name, input int want, input int got);
		if (want != got) begin
			if (error_count < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
					want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		deque_result_t want_res;
		deque_result_t got_res;
		if (arst_n && m_tvalid && m_tready) begin
			got_res = m_tdata;
			if (expected_results.size() == 0) begin
				if (error_count < REPORT_LIMIT)
					$display("%0t: unexpected result word, expected none, actual %h", $time,
						m_tdata);
				error_count++;
			end else begin
				want_res = expected_results.pop_front();
				compare_field("status", int'(want_res.status), int'(got_res.status));
				compare_field("found", int'(want_res.found), int'(got_res.found));
				compare_field("entry_count", int'(want_res.entry_count),
					int'(got_res.entry_count));
				compare_field("front_byte", int'(want_res.front_byte),
					int'(got_res.front_byte));
				compare_field("rear_byte", int'(want_res.rear_byte), int'(got_res.rear_byte));
			end
			results_checked++;
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Leaves tvalid high on return so that back-to-back words need no gap.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value);
		deque_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, value, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = predict_deque_result(op, value);
		expected_results.push_back(res);
		words_sent++;
		if (res.status == STAT_DONE && op <= OP_SEARCH)
			applied_words++;
	endtask

	task automatic wait_for_results;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[1:0] == 2'b00 && addr[PADDR_W-1:2] == REG_CAP_IDX)
			shadow_capacity = data[COUNT_W-1:0];
		capacity_writes++;
	endtask

	task automatic test_empty_deque;
		send_word(OP_POP_FRONT, 8'h00);
		send_word(OP_POP_REAR, 8'hFF);
		send_word(OP_REPLACE_REAR, 8'hFF);
		send_word(OP_SEARCH, 8'h00);
		send_word(OP_SPARE_HI, 8'hAA);
		wait_for_results();
	endtask

	task automatic test_basic_operations;
		send_word(OP_PUSH_FRONT, 8'h00);
		send_word(OP_PUSH_REAR, 8'hFF);
		send_word(OP_SEARCH, 8'hFF);
		send_word(OP_SEARCH, 8'h7F);
		send_word(OP_REPLACE_REAR, 8'h01);
		send_word(OP_SPARE_LO, 8'h55);
		send_word(OP_POP_FRONT, 8'h00);
		send_word(OP_POP_REAR, 8'h00);
		wait_for_results();
	endtask

	task automatic test_capacity_limits;
		// upper data bits carry no meaning
		write_register(CAP_ADDR, 32'hFFFF_FFE1);
		send_word(OP_PUSH_REAR, 8'h11);
		send_word(OP_PUSH_FRONT, 8'h22);
		wait_for_results();
		write_register(SPARE_ADDR, 32'd16);
		send_word(OP_PUSH_REAR, 8'h33);
		send_word(OP_POP_REAR, 8'h00);
		wait_for_results();
		write_register(CAP_ADDR, 32'd0);
		send_word(OP_PUSH_FRONT, 8'h99);
		wait_for_results();
		write_register(CAP_ADDR, 32'd31);
		send_word(OP_PUSH_REAR, 8'h44);
		send_word(OP_PUSH_FRONT, 8'h55);
		send_word(OP_PUSH_REAR, 8'hEE);
		wait_for_results();
		// held entries survive a capacity below the count
		write_register(CAP_ADDR, 32'd2);
		send_word(OP_PUSH_FRONT, 8'h66);
		send_word(OP_POP_FRONT, 8'h00);
		send_word(OP_PUSH_REAR, 8'h77);
		send_word(OP_POP_FRONT, 8'h00);
		send_word(OP_PUSH_REAR, 8'h77);
		wait_for_results();
	endtask

	task automatic run_random_segment(input logic [COUNT_W-1:0] capacity);
		int issued;
		int push_pct;
		int roll;
		logic [OP_W-1:0] op;
		logic [BYTE_W-1:0] value;
		write_register(CAP_ADDR, {27'd0, capacity});
		issued = 0;
		push_pct = 50;
		while (issued < SEGMENT_WORDS) begin
			// swing between filling, draining and balanced traffic
			if (issued % 16 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 20;
					1: push_pct = 45;
					default: push_pct = 80;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < push_pct) begin
				op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
			end else if (roll >= 97) begin
				op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
			end else begin
				case ($urandom_range(3))
					0: op = OP_POP_FRONT;
					1: op = OP_POP_REAR;
					2: op = OP_REPLACE_REAR;
					default: op = OP_SEARCH;
				endcase
			end
			case ($urandom_range(9))
				0: value = 8'h00;
				1: value = 8'hFF;
				default: value = BYTE_W'($urandom_range(255));
			endcase
			if (op == OP_SEARCH && shadow_count != 0 && $urandom_range(1))
				value = shadow_bytes[(shadow_head + $urandom_range(shadow_count - 1))
					% DEQUE_DEPTH];
			send_word(op, value);
			issued++;
		end
		wait_for_results();
	endtask

	task automatic run_pacing_phase(input int send_pct, input int recv_pct,
		input logic [COUNT_W-1:0] cap_a, input logic [COUNT_W-1:0] cap_b,
		input logic [COUNT_W-1:0] cap_c, input logic [COUNT_W-1:0] cap_d);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		run_random_segment(cap_a);
		run_random_segment(cap_b);
		run_random_segment(cap_c);
		run_random_segment(cap_d);
	endtask

	task automatic test_random_traffic;
		run_pacing_phase(0, 0, 5'd16, 5'd5, 5'd31, 5'd1);
		run_pacing_phase(76, 0, 5'd0, 5'd12, 5'd16, 5'd2);
		run_pacing_phase(0, 76, 5'd31, 5'd3, 5'd16, 5'd9);
		run_pacing_phase(31, 31, 5'd1, 5'd16, 5'd0, 5'd31);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < DEQUE_DEPTH; i++)
			shadow_bytes[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_deque();
		test_basic_operations();
		test_capacity_limits();
		test_random_traffic();
		wait_for_results();
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			error_count++;
		end
		$display("Sent %0d operation words (%0d changed or searched the deque), checked %0d results",
			words_sent, applied_words, results_checked);
		$display("over %0d capacity writes and four stall patterns; %0d mismatches",
			capacity_writes, error_count);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
